// ===== rtl/psrag_pkg.sv =====
// Shared types, widths, codes and defaults for the padded slice read address generator.
`default_nettype none
package psrag_pkg;

  localparam int MAX_DIMS_DEF       = 8;
  localparam int ALIGN_BYTES_DEF    = 64;
  localparam int UNALIGNED_MODE_DEF = 0;

  localparam int ROW_W   = 32;
  localparam int CNT_W   = 24;
  localparam int BSIZE_W = 16;
  localparam int DSTR_W  = 20;
  localparam int DCNT_W  = 4;
  localparam int SEL_W   = 3;
  localparam int OP_W    = 2;
  localparam int MIS_W   = 6;
  localparam int REG_W   = 32;
  localparam int REGI_W  = 3;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_LOAD    = 2'd0;
  localparam op_t OP_RESTART = 2'd1;
  localparam op_t OP_ISSUE   = 2'd2;

  typedef logic [REGI_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_START_ROW     = 3'd0;
  localparam reg_idx_t REG_DIM_COUNT     = 3'd1;
  localparam reg_idx_t REG_TOTAL_ROWS    = 3'd2;
  localparam reg_idx_t REG_BATCH_LIMIT   = 3'd3;
  localparam reg_idx_t REG_BATCH_SIZE    = 3'd4;
  localparam reg_idx_t REG_DEST_STRIDE   = 3'd5;
  localparam reg_idx_t REG_SOURCE_OFFSET = 3'd6;
  localparam reg_idx_t REG_ROW_BYTES     = 3'd7;

  typedef struct packed {
    logic             en;
    logic [SEL_W-1:0] sel;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] skip;
    logic [CNT_W-1:0] start;
  } dim_load_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] val;
  } pos_wr_t;

endpackage
`default_nettype wire

// ===== rtl/psrag_ifs.sv =====
// Request and response channel interfaces.
`default_nettype none
interface psrag_req_if;
  logic                           valid;
  logic                           ready;
  psrag_pkg::op_t                 op;
  logic [psrag_pkg::SEL_W-1:0]    dim_select;
  logic [psrag_pkg::CNT_W-1:0]    unpadded_count;
  logic [psrag_pkg::CNT_W-1:0]    padding_skip;
  logic [psrag_pkg::CNT_W-1:0]    start_index;
  modport source (output valid, op, dim_select, unpadded_count, padding_skip, start_index,
                  input ready);
  modport sink (input valid, op, dim_select, unpadded_count, padding_skip, start_index,
                output ready);
endinterface

interface psrag_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [psrag_pkg::ROW_W-1:0]    row_id;
  logic [psrag_pkg::ROW_W-1:0]    aligned_offset;
  logic [psrag_pkg::MIS_W-1:0]    misalign;
  logic [psrag_pkg::ROW_W-1:0]    dest_offset;
  logic [psrag_pkg::BSIZE_W-1:0]  read_len;
  logic                           batch_end;
  logic                           finished;
  modport source (output valid, row_id, aligned_offset, misalign, dest_offset, read_len,
                  batch_end, finished, input ready);
  modport sink (input valid, row_id, aligned_offset, misalign, dest_offset, read_len,
                batch_end, finished, output ready);
endinterface
`default_nettype wire

// ===== rtl/psrag_dim_table.sv =====
// Per-dimension limit, skip, start and position storage.
`default_nettype none
module psrag_dim_table #(
  parameter int MAX_DIMS = psrag_pkg::MAX_DIMS_DEF,
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire psrag_pkg::dim_load_t        load,
  input  wire logic                        restart,
  input  wire psrag_pkg::pos_wr_t          pos_wr,
  input  wire logic [DW-1:0]               idx,
  output logic [psrag_pkg::CNT_W-1:0]      rd_limit,
  output logic [psrag_pkg::CNT_W-1:0]      rd_skip,
  output logic [psrag_pkg::CNT_W-1:0]      rd_pos
);

  logic [psrag_pkg::CNT_W-1:0] limit [MAX_DIMS];
  logic [psrag_pkg::CNT_W-1:0] skip  [MAX_DIMS];
  logic [psrag_pkg::CNT_W-1:0] start [MAX_DIMS];
  logic [psrag_pkg::CNT_W-1:0] pos   [MAX_DIMS];

  logic load_ok;
  assign load_ok = load.en && (32'(load.sel) < MAX_DIMS);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        limit[d] <= '0;
        skip[d]  <= '0;
        start[d] <= '0;
        pos[d]   <= '0;
      end
    end else begin
      if (load_ok) begin
        limit[DW'(load.sel)] <= load.limit;
        skip[DW'(load.sel)]  <= load.skip;
        start[DW'(load.sel)] <= load.start;
      end
      if (restart) begin
        for (int d = 0; d < MAX_DIMS; d++) begin
          pos[d] <= start[d];
        end
      end else if (pos_wr.en) begin
        pos[idx] <= pos_wr.val;
      end
    end
  end

  assign rd_limit = limit[idx];
  assign rd_skip  = skip[idx];
  assign rd_pos   = pos[idx];

endmodule
`default_nettype wire

// ===== rtl/psrag_carry_unit.sv =====
// Shared row adder and position increment/compare used by the carry sequencer.
`default_nettype none
module psrag_carry_unit (
  input  wire logic [psrag_pkg::ROW_W-1:0] row,
  input  wire logic [psrag_pkg::ROW_W-1:0] addend,
  input  wire logic [psrag_pkg::CNT_W-1:0] pos,
  input  wire logic [psrag_pkg::CNT_W-1:0] limit,
  output logic [psrag_pkg::ROW_W-1:0]      sum,
  output logic [psrag_pkg::CNT_W-1:0]      pos_inc,
  output logic                             wrap
);

  assign sum     = row + addend;
  assign pos_inc = pos + psrag_pkg::CNT_W'(1);
  assign wrap    = (pos_inc == limit);

endmodule
`default_nettype wire

// ===== rtl/psrag_mod_unit.sv =====
// Remainder of the source offset by the alignment size, by reciprocal multiplication.
`default_nettype none
module psrag_mod_unit #(
  parameter int ALIGN_BYTES = psrag_pkg::ALIGN_BYTES_DEF,
  localparam int RW = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [psrag_pkg::ROW_W-1:0]  value,
  output logic                              busy,
  output logic [RW-1:0]                     rem
);

  localparam int ROW_W = psrag_pkg::ROW_W;
  localparam logic [2*ROW_W-1:0] RECIP_FULL = (64'd1 << ROW_W) / 64'(ALIGN_BYTES);
  localparam logic [ROW_W-1:0]   RECIP      = RECIP_FULL[ROW_W-1:0];
  localparam logic [RW:0]        DIV        = (RW+1)'(ALIGN_BYTES);

  typedef enum logic [2:0] {
    PH_MUL  = 3'b001,
    PH_FOLD = 3'b010,
    PH_FIX  = 3'b100
  } phase_t;

  phase_t             phase;
  logic [ROW_W-1:0]   value_q;
  logic [2*ROW_W-1:0] prod;
  logic [RW:0]        quot_low;
  logic [RW:0]        qa_low;
  logic [RW:0]        partial;

  assign quot_low = prod[ROW_W +: RW+1];
  assign qa_low   = quot_low * DIV;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_MUL;
      rem   <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      phase   <= PH_MUL;
      value_q <= value;
    end else if (busy) begin
      unique case (phase)
        PH_MUL: begin
          prod  <= 64'(value_q) * 64'(RECIP);
          phase <= PH_FOLD;
        end
        PH_FOLD: begin
          partial <= value_q[RW:0] - qa_low;
          phase   <= PH_FIX;
        end
        PH_FIX: begin
          if (ALIGN_BYTES == 1) begin
            rem <= '0;
          end else if (partial >= DIV) begin
            rem <= RW'(partial - DIV);
          end else begin
            rem <= RW'(partial);
          end
          busy  <= 1'b0;
          phase <= PH_MUL;
        end
        default: phase <= PH_MUL;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/padded_slice_read_address_generator.sv =====
// Top level: read request generator for a multi-dimensional padded slice.
//
// Channels: req carries commands (load a dimension entry, restart counters,
// issue one request); rsp carries one beat per issue command. cfg_we, cfg_index
// and cfg_data write the configuration registers; the user is to do so only
// while idle, as the block does not enforce it. An issue that produces a
// request walks the k dimensions the carry visits (1 to dim_count capped at
// MAX_DIMS, 0 when dim_count is zero); load, restart and a finished issue walk
// none. One shared row adder walks the dimensions one per cycle; req is not
// ready during the walk. The rsp beat is valid the cycle after the issue beat
// is taken. In the unaligned build a write of source_offset starts a remainder
// by reciprocal multiplication; req stays not ready until it completes. Reset
// clears all counters, tables and configuration registers to their reset values.
// rsp is held in an output register; a stalled receiver holds that beat, and
// req takes a new beat only when the register is free or being drained.
`default_nettype none
module padded_slice_read_address_generator #(
  parameter int MAX_DIMS       = psrag_pkg::MAX_DIMS_DEF,
  parameter int ALIGN_BYTES    = psrag_pkg::ALIGN_BYTES_DEF,
  parameter int UNALIGNED_MODE = psrag_pkg::UNALIGNED_MODE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  psrag_req_if.sink                           req,
  psrag_rsp_if.source                         rsp,
  input  wire logic                           cfg_we,
  input  wire psrag_pkg::reg_idx_t            cfg_index,
  input  wire logic [psrag_pkg::REG_W-1:0]    cfg_data
);

  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW = $clog2(MAX_DIMS + 1);
  localparam int RW = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
  localparam int ROW_W = psrag_pkg::ROW_W;
  localparam int CNT_W = psrag_pkg::CNT_W;
  localparam int BSIZE_W = psrag_pkg::BSIZE_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state;

  logic [ROW_W-1:0]   start_row;
  logic [psrag_pkg::DCNT_W-1:0] dim_count;
  logic [CNT_W-1:0]   total_rows;
  logic [CNT_W-1:0]   batch_limit;
  logic [BSIZE_W-1:0] batch_size;
  logic [psrag_pkg::DSTR_W-1:0] dest_stride;
  logic [ROW_W-1:0]   source_offset;
  logic [BSIZE_W-1:0] row_bytes;

  logic [ROW_W-1:0]   next_row;
  logic [CNT_W-1:0]   rows_done;
  logic [BSIZE_W-1:0] batch_position;
  logic [CNT_W-1:0]   batches_done;
  logic [ROW_W-1:0]   dest_accumulator;
  logic [CW-1:0]      walk_idx;

  logic                 mod_busy;
  logic [RW-1:0]        mod_rem;
  logic [RW-1:0]        mis_full;
  logic [CNT_W-1:0]     rd_limit;
  logic [CNT_W-1:0]     rd_skip;
  logic [CNT_W-1:0]     rd_pos;
  logic [ROW_W-1:0]     addend;
  logic [ROW_W-1:0]     sum;
  logic [CNT_W-1:0]     pos_inc;
  logic                 wrap;
  psrag_pkg::dim_load_t load;
  psrag_pkg::pos_wr_t   pos_wr;

  logic          accept;
  logic          is_load;
  logic          is_restart;
  logic          is_issue;
  logic          done_now;
  logic          ends;
  logic [4:0]    dc5;
  logic [4:0]    used5;
  logic [CW-1:0] used;
  logic [CW-1:0] walk_idx_inc;

  assign req.ready  = (state == ST_IDLE) && !mod_busy && (!rsp.valid || rsp.ready);
  assign accept     = req.valid && req.ready;
  assign is_load    = accept && (req.op == psrag_pkg::OP_LOAD);
  assign is_restart = accept && (req.op == psrag_pkg::OP_RESTART);
  assign is_issue   = accept && (req.op == psrag_pkg::OP_ISSUE);

  assign done_now = (rows_done >= total_rows) || (batches_done >= batch_limit) ||
                    (batch_size == '0);
  assign ends = (({1'b0, batch_position} + 17'd1) >= {1'b0, batch_size}) ||
                (({1'b0, rows_done} + 25'd1) >= {1'b0, total_rows});

  assign dc5   = {1'b0, dim_count};
  assign used5 = (dc5 > 5'(MAX_DIMS)) ? 5'(MAX_DIMS) : dc5;
  assign used  = CW'(used5);
  assign walk_idx_inc = walk_idx + CW'(1);

  assign mis_full = (UNALIGNED_MODE != 0) ? mod_rem : '0;

  assign load.en    = is_load;
  assign load.sel   = req.dim_select;
  assign load.limit = req.unpadded_count;
  assign load.skip  = req.padding_skip;
  assign load.start = req.start_index;

  assign pos_wr.en  = (state == ST_WALK);
  assign pos_wr.val = wrap ? '0 : pos_inc;

  assign addend = (state == ST_WALK) ? ROW_W'(rd_skip) : ROW_W'(1);

  psrag_dim_table #(.MAX_DIMS(MAX_DIMS)) u_table (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .restart  (is_restart),
    .pos_wr   (pos_wr),
    .idx      (walk_idx[DW-1:0]),
    .rd_limit (rd_limit),
    .rd_skip  (rd_skip),
    .rd_pos   (rd_pos)
  );

  psrag_carry_unit u_carry (
    .row     (next_row),
    .addend  (addend),
    .pos     (rd_pos),
    .limit   (rd_limit),
    .sum     (sum),
    .pos_inc (pos_inc),
    .wrap    (wrap)
  );

  psrag_mod_unit #(.ALIGN_BYTES(ALIGN_BYTES)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_we && (cfg_index == psrag_pkg::REG_SOURCE_OFFSET) && (UNALIGNED_MODE != 0)),
    .value (cfg_data),
    .busy  (mod_busy),
    .rem   (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_row     <= '0;
      dim_count     <= psrag_pkg::DCNT_W'(1);
      total_rows    <= '0;
      batch_limit   <= '0;
      batch_size    <= BSIZE_W'(1);
      dest_stride   <= '0;
      source_offset <= '0;
      row_bytes     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psrag_pkg::REG_START_ROW:     start_row     <= cfg_data;
        psrag_pkg::REG_DIM_COUNT:     dim_count     <= cfg_data[psrag_pkg::DCNT_W-1:0];
        psrag_pkg::REG_TOTAL_ROWS:    total_rows    <= cfg_data[CNT_W-1:0];
        psrag_pkg::REG_BATCH_LIMIT:   batch_limit   <= cfg_data[CNT_W-1:0];
        psrag_pkg::REG_BATCH_SIZE:    batch_size    <= cfg_data[BSIZE_W-1:0];
        psrag_pkg::REG_DEST_STRIDE:   dest_stride   <= cfg_data[psrag_pkg::DSTR_W-1:0];
        psrag_pkg::REG_SOURCE_OFFSET: source_offset <= cfg_data;
        psrag_pkg::REG_ROW_BYTES:     row_bytes     <= cfg_data[BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      next_row         <= '0;
      rows_done        <= '0;
      batch_position   <= '0;
      batches_done     <= '0;
      dest_accumulator <= '0;
      walk_idx         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (is_restart) begin
            next_row         <= start_row;
            rows_done        <= '0;
            batch_position   <= '0;
            batches_done     <= '0;
            dest_accumulator <= '0;
          end else if (is_issue && !done_now) begin
            next_row  <= sum;
            rows_done <= rows_done + CNT_W'(1);
            if (ends) begin
              batch_position   <= '0;
              dest_accumulator <= '0;
              batches_done     <= batches_done + CNT_W'(1);
            end else begin
              batch_position   <= batch_position + BSIZE_W'(1);
              dest_accumulator <= dest_accumulator + ROW_W'(dest_stride);
            end
            walk_idx <= '0;
            if (used != '0) begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (wrap) begin
            next_row <= sum;
            walk_idx <= walk_idx_inc;
            if (walk_idx_inc == used) begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (is_issue) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_issue) begin
      if (done_now) begin
        rsp.row_id         <= '0;
        rsp.aligned_offset <= '0;
        rsp.misalign       <= '0;
        rsp.dest_offset    <= '0;
        rsp.read_len       <= '0;
        rsp.batch_end      <= 1'b0;
        rsp.finished       <= 1'b1;
      end else begin
        rsp.row_id         <= next_row;
        rsp.aligned_offset <= source_offset - ROW_W'(mis_full);
        rsp.misalign       <= psrag_pkg::MIS_W'(mis_full);
        rsp.dest_offset    <= dest_accumulator;
        rsp.read_len       <= row_bytes;
        rsp.batch_end      <= ends;
        rsp.finished       <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/padded_slice_read_address_generator_tb.sv =====
// Testbench for the padded slice read address generator: scripted and random command streams checked against a walker model.
`default_nettype none
module padded_slice_read_address_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psrag_pkg::*;

  localparam int DIMS          = MAX_DIMS_DEF;
  localparam int ALIGN         = ALIGN_BYTES_DEF;
  localparam int UNALIGNED     = UNALIGNED_MODE_DEF;
  localparam op_t OP_UNUSED    = 2'd3;
  localparam int SETTLE_CYCLES = DIMS + 4;
  localparam int HOLD_CYCLES   = 160;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 123;
  localparam int BOOT_ROWS     = 4;
  localparam int SCRIPT_ROWS   = 20;
  localparam int MAX_REPORTS   = 40;

  typedef enum int {SET_DIRECTED, SET_MAX, SET_ZERO, SET_RANDOM} setting_t;

  typedef struct packed {
    op_t              op;
    logic [SEL_W-1:0] sel;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] skip;
    logic [CNT_W-1:0] start;
  } command_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_id;
    logic [ROW_W-1:0]   aligned_offset;
    logic [MIS_W-1:0]   misalign;
    logic [ROW_W-1:0]   dest_offset;
    logic [BSIZE_W-1:0] read_len;
    logic               batch_end;
    logic               finished;
  } read_request_t;

  typedef struct packed {
    command_t      cmd;
    logic          pinned;
    read_request_t want;
  } script_row_t;

  typedef struct packed {
    logic          on;
    read_request_t beat;
  } pin_t;

  localparam read_request_t NO_BEAT       = '0;
  localparam read_request_t FINISHED_BEAT = '{finished: 1'b1, default: '0};
  localparam read_request_t FIRST_WALK_BEAT = '{row_id: 32'hFFFF_FFFE,
                                                aligned_offset: 32'hFFFF_FFC0,
                                                read_len: 16'hFFFF, default: '0};
  localparam command_t ISSUE_CMD   = '{OP_ISSUE, 3'd0, 24'd0, 24'd0, 24'd0};
  localparam command_t RESTART_CMD = '{OP_RESTART, 3'd0, 24'd0, 24'd0, 24'd0};

  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{ISSUE_CMD, 1'b1, FINISHED_BEAT},
    '{'{OP_UNUSED, 3'd7, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, NO_BEAT},
    '{RESTART_CMD, 1'b0, NO_BEAT},
    '{ISSUE_CMD, 1'b1, FINISHED_BEAT},
    '{'{OP_LOAD, 3'd0, 24'd3, 24'hFFFFFF, 24'd0}, 1'b0, NO_BEAT},
    '{'{OP_LOAD, 3'd1, 24'hFFFFFF, 24'd5, 24'hFFFFFE}, 1'b0, NO_BEAT},
    '{'{OP_LOAD, 3'd2, 24'd0, 24'd0, 24'd0}, 1'b0, NO_BEAT},
    '{'{OP_LOAD, 3'd7, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, NO_BEAT},
    '{RESTART_CMD, 1'b0, NO_BEAT},
    '{ISSUE_CMD, 1'b1, FIRST_WALK_BEAT},
    '{ISSUE_CMD, 1'b0, NO_BEAT},
    '{ISSUE_CMD, 1'b0, NO_BEAT},
    '{ISSUE_CMD, 1'b0, NO_BEAT},
    '{ISSUE_CMD, 1'b0, NO_BEAT},
    '{ISSUE_CMD, 1'b0, NO_BEAT},
    '{ISSUE_CMD, 1'b1, FINISHED_BEAT},
    '{ISSUE_CMD, 1'b1, FINISHED_BEAT},
    '{RESTART_CMD, 1'b0, NO_BEAT},
    '{ISSUE_CMD, 1'b0, NO_BEAT},
    '{ISSUE_CMD, 1'b0, NO_BEAT}
  };

  logic                clk;
  logic                rst;
  logic                cfg_we;
  reg_idx_t            cfg_index;
  logic [REG_W-1:0]    cfg_data;

  psrag_req_if req_ch();
  psrag_rsp_if rsp_ch();

  padded_slice_read_address_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [ROW_W-1:0]   cfg_start_row;
  logic [DCNT_W-1:0]  cfg_dim_count;
  logic [CNT_W-1:0]   cfg_total_rows;
  logic [CNT_W-1:0]   cfg_batch_limit;
  logic [BSIZE_W-1:0] cfg_batch_size;
  logic [DSTR_W-1:0]  cfg_dest_stride;
  logic [ROW_W-1:0]   cfg_source_offset;
  logic [BSIZE_W-1:0] cfg_row_bytes;

  logic [ROW_W-1:0]   cur_row;
  logic [CNT_W-1:0]   dim_pos   [DIMS];
  logic [CNT_W-1:0]   dim_lim   [DIMS];
  logic [CNT_W-1:0]   dim_skp   [DIMS];
  logic [CNT_W-1:0]   dim_org   [DIMS];
  logic [CNT_W-1:0]   rows_done;
  logic [BSIZE_W-1:0] batch_pos;
  logic [CNT_W-1:0]   batches_done;
  logic [ROW_W-1:0]   dest_acc;

  read_request_t expected_reads [$];
  pin_t          pin_q [$];

  bit  quiet;
  int  hold_requests;
  int  mismatches;
  int  commands_sent;
  int  settings_applied;
  int  beats_checked;
  int  batch_ends_seen;
  int  finished_seen;
  int  dead_cycles;

  logic          walker_emits;
  read_request_t walker_beat;
  pin_t          head_pin;
  command_t      seen_cmd;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void restart_walk();
    cur_row = cfg_start_row;
    for (int d = 0; d < DIMS; d++) dim_pos[d] = dim_org[d];
    rows_done    = '0;
    batch_pos    = '0;
    batches_done = '0;
    dest_acc     = '0;
  endfunction

  function automatic void reset_walker();
    cfg_start_row     = '0;
    cfg_dim_count     = 4'd1;
    cfg_total_rows    = '0;
    cfg_batch_limit   = '0;
    cfg_batch_size    = 16'd1;
    cfg_dest_stride   = '0;
    cfg_source_offset = '0;
    cfg_row_bytes     = '0;
    for (int d = 0; d < DIMS; d++) begin
      dim_lim[d] = '0;
      dim_skp[d] = '0;
      dim_org[d] = '0;
    end
    restart_walk();
  endfunction

  function automatic void step_walker(input command_t c, output logic emits,
                                      output read_request_t r);
    logic [ROW_W-1:0] mis_full;
    logic             closes;
    int               used;
    emits = 1'b0;
    r = '0;
    case (c.op)
      OP_LOAD: begin
        if (int'(c.sel) < DIMS) begin
          dim_lim[c.sel] = c.count;
          dim_skp[c.sel] = c.skip;
          dim_org[c.sel] = c.start;
        end
      end
      OP_RESTART: restart_walk();
      OP_ISSUE: begin
        emits = 1'b1;
        if (rows_done >= cfg_total_rows || batches_done >= cfg_batch_limit ||
            cfg_batch_size == '0) begin
          r.finished = 1'b1;
        end else begin
          mis_full = (UNALIGNED != 0) ? cfg_source_offset % 32'(ALIGN) : 32'd0;
          closes = ({16'd0, batch_pos} + 32'd1 >= {16'd0, cfg_batch_size}) ||
                   ({8'd0, rows_done} + 32'd1 >= {8'd0, cfg_total_rows});
          r.row_id         = cur_row;
          r.aligned_offset = cfg_source_offset - mis_full;
          r.misalign       = mis_full[MIS_W-1:0];
          r.dest_offset    = dest_acc;
          r.read_len       = cfg_row_bytes;
          r.batch_end      = closes;
          rows_done = rows_done + 1'b1;
          if (closes) begin
            batch_pos    = '0;
            dest_acc     = '0;
            batches_done = batches_done + 1'b1;
          end else begin
            batch_pos = batch_pos + 1'b1;
            dest_acc  = dest_acc + 32'(cfg_dest_stride);
          end
          used = (int'(cfg_dim_count) > DIMS) ? DIMS : int'(cfg_dim_count);
          cur_row = cur_row + 32'd1;
          for (int d = 0; d < used; d++) begin
            dim_pos[d] = dim_pos[d] + 1'b1;
            if (dim_pos[d] != dim_lim[d]) break;
            dim_pos[d] = '0;
            cur_row = cur_row + 32'(dim_skp[d]);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] noisy(input logic [REG_W-1:0] v, input int w);
    logic [REG_W-1:0] keep;
    keep = (w >= REG_W) ? '1 : ((32'd1 << w) - 32'd1);
    return (v & keep) | ($urandom & ~keep);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s got %h expected %h", $time, what, got, want);
  endtask

  task automatic check_beat(input read_request_t want);
    beats_checked++;
    if (want.batch_end) batch_ends_seen++;
    if (want.finished) finished_seen++;
    if (rsp_ch.row_id !== want.row_id)
      report_mismatch("row_id", rsp_ch.row_id, want.row_id);
    if (rsp_ch.aligned_offset !== want.aligned_offset)
      report_mismatch("aligned_offset", rsp_ch.aligned_offset, want.aligned_offset);
    if (rsp_ch.misalign !== want.misalign)
      report_mismatch("misalign", 32'(rsp_ch.misalign), 32'(want.misalign));
    if (rsp_ch.dest_offset !== want.dest_offset)
      report_mismatch("dest_offset", rsp_ch.dest_offset, want.dest_offset);
    if (rsp_ch.read_len !== want.read_len)
      report_mismatch("read_len", 32'(rsp_ch.read_len), 32'(want.read_len));
    if (rsp_ch.batch_end !== want.batch_end)
      report_mismatch("batch_end", 32'(rsp_ch.batch_end), 32'(want.batch_end));
    if (rsp_ch.finished !== want.finished)
      report_mismatch("finished", 32'(rsp_ch.finished), 32'(want.finished));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_reads.size() == 0)
          report_mismatch("beat with nothing expected, row_id", rsp_ch.row_id, '0);
        else
          check_beat(expected_reads.pop_front());
      end
      if (req_ch.valid && req_ch.ready) begin
        seen_cmd = '{req_ch.op, req_ch.dim_select, req_ch.unpadded_count,
                     req_ch.padding_skip, req_ch.start_index};
        step_walker(seen_cmd, walker_emits, walker_beat);
        head_pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
        if (walker_emits)
          expected_reads.insert(expected_reads.size(),
                                head_pin.on ? head_pin.beat : walker_beat);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
      dead_cycles = 0;
    else
      dead_cycles++;
    if (dead_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles, %0d reads still expected",
               STALL_LIMIT, expected_reads.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= quiet || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_START_ROW:     cfg_start_row     = data;
      REG_DIM_COUNT:     cfg_dim_count     = data[DCNT_W-1:0];
      REG_TOTAL_ROWS:    cfg_total_rows    = data[CNT_W-1:0];
      REG_BATCH_LIMIT:   cfg_batch_limit   = data[CNT_W-1:0];
      REG_BATCH_SIZE:    cfg_batch_size    = data[BSIZE_W-1:0];
      REG_DEST_STRIDE:   cfg_dest_stride   = data[DSTR_W-1:0];
      REG_SOURCE_OFFSET: cfg_source_offset = data;
      REG_ROW_BYTES:     cfg_row_bytes     = data[BSIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t kind);
    logic [REG_W-1:0] first_row, dims, total, blimit, bsize, stride, offset, nbytes;
    case (kind)
      SET_DIRECTED: begin
        first_row = 32'hFFFF_FFFE;
        dims      = 32'hFFFF_FFF2;
        total     = 32'hAB00_0006;
        blimit    = 32'h00FF_FFFF;
        bsize     = 32'h5A5A_0004;
        stride    = 32'h000F_FFFF;
        offset    = 32'hFFFF_FFC0;
        nbytes    = 32'h0000_FFFF;
      end
      SET_MAX: begin
        first_row = '1; dims = '1; total = '1; blimit = '1;
        bsize = '1; stride = '1; offset = '1; nbytes = '1;
      end
      SET_ZERO: begin
        first_row = '0; dims = '0; total = '0; blimit = '0;
        bsize = '0; stride = '0; offset = '0; nbytes = '0;
      end
      default: begin
        first_row = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15) : $urandom;
        dims = noisy(($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, DIMS),
                     DCNT_W);
        case ($urandom_range(9))
          0, 1:    total = noisy($urandom, CNT_W);
          2:       total = noisy(32'd0, CNT_W);
          default: total = noisy($urandom_range(1, 60), CNT_W);
        endcase
        case ($urandom_range(9))
          0:             blimit = noisy($urandom, CNT_W);
          1, 2, 3, 4:    blimit = noisy(32'h00FF_FFFF, CNT_W);
          default:       blimit = noisy($urandom_range(1, 10), CNT_W);
        endcase
        case ($urandom_range(9))
          0, 1:    bsize = noisy($urandom, BSIZE_W);
          2, 3:    bsize = noisy(32'd1, BSIZE_W);
          default: bsize = noisy($urandom_range(1, 7), BSIZE_W);
        endcase
        stride = noisy($urandom, DSTR_W);
        offset = $urandom;
        nbytes = noisy($urandom, BSIZE_W);
      end
    endcase
    write_reg(REG_START_ROW, first_row);
    write_reg(REG_DIM_COUNT, dims);
    write_reg(REG_TOTAL_ROWS, total);
    write_reg(REG_BATCH_LIMIT, blimit);
    write_reg(REG_BATCH_SIZE, bsize);
    write_reg(REG_DEST_STRIDE, stride);
    write_reg(REG_SOURCE_OFFSET, offset);
    write_reg(REG_ROW_BYTES, nbytes);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_cmd(input command_t c, input logic pinned, input read_request_t want);
    if (!quiet && $urandom_range(99) < 20) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pin_q.insert(pin_q.size(), pin_t'{pinned, want});
    req_ch.valid          <= 1'b1;
    req_ch.op             <= c.op;
    req_ch.dim_select     <= c.sel;
    req_ch.unpadded_count <= c.count;
    req_ch.padding_skip   <= c.skip;
    req_ch.start_index    <= c.start;
    do @(posedge clk); while (!req_ch.ready);
    commands_sent++;
  endtask

  task automatic finish_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    command_t c;
    setting_t kind;
    int       sent;
    int       r;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_START_ROW;
    cfg_data              <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.op             <= OP_LOAD;
    req_ch.dim_select     <= '0;
    req_ch.unpadded_count <= '0;
    req_ch.padding_skip   <= '0;
    req_ch.start_index    <= '0;
    quiet = 1'b0;
    hold_requests = 0;
    mismatches = 0;
    reset_walker();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (i == BOOT_ROWS) begin
        finish_results();
        apply_setting(SET_DIRECTED);
      end
      send_cmd(SCRIPT[i].cmd, SCRIPT[i].pinned, SCRIPT[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      finish_results();
      if (p == 1) kind = SET_MAX;
      else if (p == 2) kind = SET_ZERO;
      else kind = SET_RANDOM;
      apply_setting(kind);
      quiet = (p == 3);
      if (p == 4) hold_requests++;
      sent = 0;
      for (int d = 0; d < DIMS; d++) begin
        c.op    = OP_LOAD;
        c.sel   = SEL_W'(d);
        c.count = ($urandom_range(9) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 3));
        c.skip  = ($urandom_range(4) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 7));
        c.start = (c.count != '0 && $urandom_range(9) != 0) ?
                  CNT_W'($urandom_range(0, c.count - 1'b1)) : CNT_W'($urandom);
        send_cmd(c, 1'b0, NO_BEAT);
        sent++;
      end
      send_cmd(RESTART_CMD, 1'b0, NO_BEAT);
      sent++;
      while (sent < PHASE_ITEMS) begin
        r       = $urandom_range(99);
        c.sel   = SEL_W'($urandom);
        c.count = CNT_W'($urandom);
        c.skip  = CNT_W'($urandom);
        c.start = CNT_W'($urandom);
        if (r < 4) begin
          c.op = OP_UNUSED;
        end else if (r < 12) begin
          c.op = OP_LOAD;
          if ($urandom_range(3) != 0) begin
            c.count = CNT_W'($urandom_range(1, 5));
            c.skip  = CNT_W'($urandom_range(0, 9));
            c.start = CNT_W'($urandom_range(0, c.count - 1'b1));
          end
        end else if (r < 20) begin
          c.op = OP_RESTART;
        end else begin
          c.op = OP_ISSUE;
        end
        send_cmd(c, 1'b0, NO_BEAT);
        if (c.op != OP_UNUSED) begin
          sent++;
          if (p == 5 && sent == PHASE_ITEMS / 2) finish_results();
        end
      end
    end
    finish_results();

    $display("ran %0d commands under %0d register settings; %0d read beats checked",
             commands_sent, settings_applied, beats_checked);
    $display("%0d beats closed a batch, %0d reported the walk finished",
             batch_ends_seen, finished_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
